### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/msgtmr_pkg.sv
// ---------------------------------------------------------------------------
// msgtmr_pkg
// Types, codes and sizes of the message slot table with timers.
// ---------------------------------------------------------------------------
package msgtmr_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_PEEK   = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [0:0]  REG_TIMER_MSG_ID = 1'b0;
    localparam logic [31:0] TIMER_MSG_ID_RST = 32'd275;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] msg_id;
        logic [31:0] word_param;
        logic [31:0] long_param;
        logic [31:0] now_tick;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_msg_id;
        logic [31:0] out_word_param;
        logic [31:0] out_long_param;
    } rsp_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] word_p;
        logic [31:0] long_p;
        logic [31:0] stamp;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

### src/msgtmr_ram.sv
// ---------------------------------------------------------------------------
// msgtmr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module msgtmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/message_slot_table_with_timers.sv
// ---------------------------------------------------------------------------
// message_slot_table_with_timers
// Slot table of messages and periodic timers, held in one RAM and scanned
// in slot order for add, peek and remove requests.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      msgtmr_pkg::req_t
//   m_       out        m_valid / m_ready      msgtmr_pkg::rsp_t
//   apb      in         psel/penable/pready    timer_msg_id at address 0
//
// The slot scan reads one RAM entry per cycle and checks the entry in the
// cycle after the read.
// Add and peek stop at their first hit, remove always visits every slot.
// Reset clears the valid marks at once; no clearing pass is needed.
// A stalled m_ready holds the result in the output register; the next
// request is taken meanwhile and waits in its final state until the
// output register frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module message_slot_table_with_timers (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  msgtmr_pkg::req_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output msgtmr_pkg::rsp_t               m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [msgtmr_pkg::PADDR_W-1:0] paddr,
    input  logic [msgtmr_pkg::PDATA_W-1:0] pwdata,
    output logic [msgtmr_pkg::PDATA_W-1:0] prdata,
    output logic                           pready
);

    import msgtmr_pkg::*;

    state_t             state_reg,      state_next;
    req_t               req_reg,        req_next;
    logic [CNT_W-1:0]   scan_idx_reg,   scan_idx_next;
    logic               ev_vld_reg,     ev_vld_next;
    logic [IDX_W-1:0]   ev_idx_reg,     ev_idx_next;
    logic [SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    rsp_t               res_reg,        res_next;
    logic               m_valid_reg,    m_valid_next;
    rsp_t               m_data_reg,     m_data_next;
    logic [31:0]        timer_id_reg,   timer_id_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    slot_t              ram_wdata;
    logic [SLOT_W-1:0]  ram_rdata;
    slot_t              rd_slot;
    logic               cur_valid;
    logic               is_timer;
    logic [31:0]        elapsed;
    logic               due;
    logic               last;
    logic               hit;
    logic               cfg_wr;
    logic [0:0]         cfg_idx;

    msgtmr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_slot   = slot_t'(ram_rdata);
    assign cur_valid = slot_valid_reg[ev_idx_reg];
    assign is_timer  = (rd_slot.id == timer_id_reg);
    assign elapsed   = req_reg.now_tick - rd_slot.stamp;
    assign due       = (elapsed >= rd_slot.long_p);
    assign last      = (ev_idx_reg == IDX_W'(SLOTS - 1));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (cfg_idx == REG_TIMER_MSG_ID) ? timer_id_reg : '0;

    always_comb begin
        timer_id_next = timer_id_reg;
        if (cfg_wr && (cfg_idx == REG_TIMER_MSG_ID)) begin
            timer_id_next = pwdata;
        end
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        scan_idx_next   = scan_idx_reg;
        ev_vld_next     = 1'b0;
        ev_idx_next     = ev_idx_reg;
        slot_valid_next = slot_valid_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = ev_idx_reg;
        ram_wdata       = '0;
        hit             = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_data;
                    scan_idx_next = '0;
                    res_next      = '0;
                    if ((s_data.req_type == REQ_ADD) || (s_data.req_type == REQ_PEEK) ||
                        (s_data.req_type == REQ_REMOVE)) begin
                        state_next = ST_SCAN;
                    end else begin
                        res_next.status = STATUS_OK;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg < CNT_W'(SLOTS)) begin
                    ev_vld_next   = 1'b1;
                    ev_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (ev_vld_reg) begin
                    unique case (req_reg.req_type)
                        REQ_ADD: begin
                            if (!cur_valid) begin
                                ram_we                      = 1'b1;
                                ram_wdata.id                = req_reg.msg_id;
                                ram_wdata.word_p            = req_reg.word_param;
                                ram_wdata.long_p            = req_reg.long_param;
                                ram_wdata.stamp             = req_reg.now_tick;
                                slot_valid_next[ev_idx_reg] = 1'b1;
                                hit                         = 1'b1;
                                res_next                    = '0;
                                res_next.status             = STATUS_OK;
                            end
                        end
                        REQ_PEEK: begin
                            if (cur_valid && (!is_timer || due)) begin
                                hit                     = 1'b1;
                                res_next.status         = STATUS_OK;
                                res_next.out_msg_id     = rd_slot.id;
                                res_next.out_word_param = rd_slot.word_p;
                                res_next.out_long_param = rd_slot.long_p;
                                if (is_timer) begin
                                    ram_we          = 1'b1;
                                    ram_wdata       = rd_slot;
                                    ram_wdata.stamp = req_reg.now_tick;
                                end else begin
                                    slot_valid_next[ev_idx_reg] = 1'b0;
                                end
                            end
                        end
                        REQ_REMOVE: begin
                            if (cur_valid && (rd_slot.id == req_reg.msg_id) &&
                                (rd_slot.word_p == req_reg.word_param)) begin
                                slot_valid_next[ev_idx_reg] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                    if (hit) begin
                        ev_vld_next = 1'b0;
                        state_next  = ST_DONE;
                    end else if (last) begin
                        ev_vld_next = 1'b0;
                        res_next    = '0;
                        state_next  = ST_DONE;
                        if (req_reg.req_type == REQ_ADD) begin
                            res_next.status = STATUS_FULL;
                        end else if (req_reg.req_type == REQ_PEEK) begin
                            res_next.status = STATUS_EMPTY;
                        end else begin
                            res_next.status = STATUS_OK;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ev_vld_reg     <= 1'b0;
            slot_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
            timer_id_reg   <= TIMER_MSG_ID_RST;
        end else begin
            state_reg      <= state_next;
            ev_vld_reg     <= ev_vld_next;
            slot_valid_reg <= slot_valid_next;
            m_valid_reg    <= m_valid_next;
            timer_id_reg   <= timer_id_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        scan_idx_reg <= scan_idx_next;
        ev_idx_reg   <= ev_idx_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    `CHK_IMPLY(a_we_in_scan, ram_we, ev_vld_reg && (state_reg == ST_SCAN), "RAM write outside scan")
    `CHK_NEXT(a_written_valid, ram_we, slot_valid_reg[$past(ev_idx_reg)], "written slot not valid")
    `CHK_IMPLY(a_full_all_valid, (state_reg == ST_DONE) && (res_reg.status == STATUS_FULL), &slot_valid_reg, "full with free slot")
    `CHK_IMPLY(a_eval_in_scan, ev_vld_reg, state_reg == ST_SCAN, "slot check outside scan")

endmodule
